// ===== sv/psb_pkg.sv =====
// Shared types and constants for the positional sequence buffer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psb_pkg;

  localparam int DEPTH      = 16;
  localparam int VALUE_BITS = 32;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS   = $clog2(DEPTH + 1);

  localparam int OP_BITS    = 3;
  localparam int POS_BITS   = 4;
  localparam int DATA_BITS  = 32;
  localparam int STAT_BITS  = 2;
  localparam int COUNT_BITS = 5;

  localparam int IN_BITS    = 40;
  localparam int OUT_BITS   = 48;

  typedef enum logic [OP_BITS-1:0] {
    OP_READ   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_INSERT = 3'd2,
    OP_APPEND = 3'd3,
    OP_REMOVE = 3'd4
  } op_t;

  typedef enum logic [STAT_BITS-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_UP_RD,
    S_UP_WR,
    S_INS_WR,
    S_DN_RD,
    S_DN_WR
  } state_t;

  // Result item, first field in the highest bits (read_value in the lowest).
  typedef struct packed {
    logic                  is_full;
    logic                  is_empty;
    logic [COUNT_BITS-1:0] count;
    status_t               status;
    logic [DATA_BITS-1:0]  read_value;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/psb_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port,
// read data registered. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module psb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/positional_sequence_buffer.sv =====
// Positional sequence buffer: ordered store of up to DEPTH values in one RAM.
// Depends on psb_pkg and psb_ram.
// Overwrite, append, ignored ops, rejected requests and removal of the last entry load their
// result straight from idle; a read loads it from the registered RAM data in S_RD_WAIT; insert
// and remove walk the shift one entry at a time, reading then writing it through the one read port.
// Throughput: one request at a time; take the next once the result can leave.
// Reset clears the fill count and the result valid flag; RAM contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module positional_sequence_buffer (
  input  wire                          clk,
  input  wire                          rst,
  // s_tdata: op[2:0], position[6:3], value[38:7], zero pad[39]
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire [psb_pkg::IN_BITS-1:0]   s_tdata,
  // m_tdata: read_value[31:0], status[33:32], count[38:34], is_empty[39],
  //          is_full[40], zero pad[47:41]
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [psb_pkg::OUT_BITS-1:0] m_tdata
);
  import psb_pkg::*;

  // Unpack the incoming transfer.
  logic [OP_BITS-1:0]   in_op;
  logic [POS_BITS-1:0]  in_position;
  logic [DATA_BITS-1:0] in_value;

  assign in_op       = s_tdata[OP_BITS-1:0];
  assign in_position = s_tdata[OP_BITS +: POS_BITS];
  assign in_value    = s_tdata[OP_BITS+POS_BITS +: DATA_BITS];

  // Control and request registers.
  state_t                state, state_next;
  logic [CNT_BITS-1:0]   fill_count, fill_count_next;
  logic [ADDR_BITS-1:0]  idx, idx_next;
  logic [ADDR_BITS-1:0]  pos_r, pos_r_next;
  logic [VALUE_BITS-1:0] val_r, val_r_next;

  // Output register.
  result_t result, result_next;
  logic    load_result;

  // RAM ports.
  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic [ADDR_BITS-1:0]  ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;

  logic accept;
  logic in_range;
  logic is_full_now;

  psb_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Take a new request only between walks and with room in the output register.
  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  // The fill count never exceeds DEPTH, so this also keeps the position inside the store.
  assign in_range    = (CNT_BITS'(in_position) < fill_count);
  assign is_full_now = (fill_count >= CNT_BITS'(DEPTH));

  function automatic result_t make_result(status_t st, logic [VALUE_BITS-1:0] rd,
                                          logic [CNT_BITS-1:0] cnt);
    result_t r;
    r.read_value = DATA_BITS'(rd);
    r.status     = st;
    r.count      = COUNT_BITS'(cnt);
    r.is_empty   = (cnt == '0);
    r.is_full    = (cnt == CNT_BITS'(DEPTH));
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      if (load_result) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    idx   <= idx_next;
    pos_r <= pos_r_next;
    val_r <= val_r_next;
    if (load_result) begin
      result <= result_next;
    end
  end

  assign m_tdata = {(OUT_BITS - $bits(result_t))'(0), result};

  always_comb begin
    state_next      = state;
    fill_count_next = fill_count;
    idx_next        = idx;
    pos_r_next      = pos_r;
    val_r_next      = val_r;
    load_result     = 1'b0;
    result_next     = make_result(ST_DONE, '0, fill_count);
    ram_we          = 1'b0;
    ram_waddr       = idx;
    ram_wdata       = val_r;
    ram_raddr       = idx;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          pos_r_next = ADDR_BITS'(in_position);
          val_r_next = VALUE_BITS'(in_value);
          unique case (in_op)
            OP_READ: begin
              if (in_range) begin
                // Fetch the entry; the result is loaded in S_RD_WAIT from the registered read data.
                ram_raddr  = ADDR_BITS'(in_position);
                state_next = S_RD_WAIT;
              end else begin
                load_result = 1'b1;
                result_next = make_result(ST_RANGE, '0, fill_count);
              end
            end
            OP_WRITE: begin
              load_result = 1'b1;
              if (in_range) begin
                ram_we      = 1'b1;
                ram_waddr   = ADDR_BITS'(in_position);
                ram_wdata   = VALUE_BITS'(in_value);
                result_next = make_result(ST_DONE, '0, fill_count);
              end else begin
                result_next = make_result(ST_RANGE, '0, fill_count);
              end
            end
            OP_INSERT: begin
              if (!in_range) begin
                load_result = 1'b1;
                result_next = make_result(ST_RANGE, '0, fill_count);
              end else if (is_full_now) begin
                load_result = 1'b1;
                result_next = make_result(ST_FULL, '0, fill_count);
              end else begin
                // Walk down from the first free slot, moving each entry up.
                idx_next   = ADDR_BITS'(fill_count);
                state_next = S_UP_RD;
              end
            end
            OP_APPEND: begin
              load_result = 1'b1;
              if (is_full_now) begin
                result_next = make_result(ST_FULL, '0, fill_count);
              end else begin
                ram_we          = 1'b1;
                ram_waddr       = ADDR_BITS'(fill_count);
                ram_wdata       = VALUE_BITS'(in_value);
                fill_count_next = fill_count + 1'b1;
                result_next     = make_result(ST_DONE, '0, fill_count + 1'b1);
              end
            end
            OP_REMOVE: begin
              if (!in_range) begin
                load_result = 1'b1;
                result_next = make_result(ST_RANGE, '0, fill_count);
              end else if (CNT_BITS'(in_position) + 1'b1 == fill_count) begin
                // Last entry: nothing to shift, just drop it.
                load_result     = 1'b1;
                fill_count_next = fill_count - 1'b1;
                result_next     = make_result(ST_DONE, '0, fill_count - 1'b1);
              end else begin
                idx_next   = ADDR_BITS'(in_position);
                state_next = S_DN_RD;
              end
            end
            default: begin
              // Unused op codes: report done, change nothing.
              load_result = 1'b1;
              result_next = make_result(ST_DONE, '0, fill_count);
            end
          endcase
        end
      end

      S_RD_WAIT: begin
        load_result = 1'b1;
        result_next = make_result(ST_DONE, ram_rdata, fill_count);
        state_next  = S_IDLE;
      end

      S_UP_RD: begin
        ram_raddr  = idx - 1'b1;
        state_next = S_UP_WR;
      end

      S_UP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = ram_rdata;
        if (CNT_BITS'(idx) == CNT_BITS'(pos_r) + 1'b1) begin
          state_next = S_INS_WR;
        end else begin
          idx_next   = idx - 1'b1;
          state_next = S_UP_RD;
        end
      end

      S_INS_WR: begin
        // Slot at the position is free now: place the new value.
        ram_we          = 1'b1;
        ram_waddr       = pos_r;
        ram_wdata       = val_r;
        fill_count_next = fill_count + 1'b1;
        load_result     = 1'b1;
        result_next     = make_result(ST_DONE, '0, fill_count + 1'b1);
        state_next      = S_IDLE;
      end

      S_DN_RD: begin
        ram_raddr  = idx + 1'b1;
        state_next = S_DN_WR;
      end

      S_DN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = ram_rdata;
        if (CNT_BITS'(idx) + 2'd2 >= fill_count) begin
          // Last valid entry moved down; shrink the store.
          fill_count_next = fill_count - 1'b1;
          load_result     = 1'b1;
          result_next     = make_result(ST_DONE, '0, fill_count - 1'b1);
          state_next      = S_IDLE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_DN_RD;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking bench for positional_sequence_buffer: directed table plus random traffic.
// Depends on psb_pkg and the buffer RTL.
`timescale 1ns / 1ps

module tb;
  import psb_pkg::*;

  // Reserved op codes: the buffer must ignore them.
  localparam logic [OP_BITS-1:0] OP_RSVD_A = 3'd5;
  localparam logic [OP_BITS-1:0] OP_RSVD_B = 3'd6;
  localparam logic [OP_BITS-1:0] OP_RSVD_C = 3'd7;

  localparam int ITEMS      = 1600;
  localparam int QUIET_TAIL = 2 * DEPTH + 8;  // longer than the slowest insert
  localparam int STALL_CAP  = 2000;           // cycles with no transfer on either side

  typedef struct {
    logic [OP_BITS-1:0]   op;
    logic [POS_BITS-1:0]  pos;
    logic [DATA_BITS-1:0] value;
    int                   reps;
    bit                   typed;
    result_t              want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_BITS-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_BITS-1:0] m_tdata;

  // Shadow copy of the store, updated on every accepted request.
  logic [DATA_BITS-1:0] shadow [DEPTH];
  int unsigned          level = 0;

  result_t   pending_results [$];
  plan_row_t directed_plan [$];
  int        errors = 0;
  bit        idle_on = 1'b1;
  int        stall_left = 0;
  int        quiet_cycles = 0;
  result_t   got;
  result_t   want;

  positional_sequence_buffer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Build a result from its visible fields; the flags follow from the count.
  function automatic result_t outcome(logic [DATA_BITS-1:0] rd, status_t st, int cnt);
    result_t r;
    r.read_value = rd;
    r.status     = st;
    r.count      = COUNT_BITS'(cnt);
    r.is_empty   = (cnt == 0);
    r.is_full    = (cnt == DEPTH);
    return r;
  endfunction

  function automatic void plan_step(logic [OP_BITS-1:0] op, logic [POS_BITS-1:0] pos,
                                    logic [DATA_BITS-1:0] value, int reps, bit typed,
                                    result_t want_r);
    plan_row_t row;
    row.op    = op;
    row.pos   = pos;
    row.value = value;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want_r;
    directed_plan = {directed_plan, row};
  endfunction

  // Apply one request to the shadow store and return the result it must produce.
  function automatic result_t apply_request(logic [OP_BITS-1:0] op, logic [POS_BITS-1:0] pos,
                                            logic [DATA_BITS-1:0] value);
    logic [DATA_BITS-1:0] rd;
    status_t              st;
    bit                   hit;
    rd  = '0;
    st  = ST_DONE;
    hit = (pos < level);
    case (op)
      OP_READ: begin
        if (!hit) st = ST_RANGE;
        else rd = shadow[pos];
      end
      OP_WRITE: begin
        if (!hit) st = ST_RANGE;
        else shadow[pos] = value;
      end
      OP_INSERT: begin
        // Position check wins over the full check.
        if (!hit) begin
          st = ST_RANGE;
        end else if (level >= DEPTH) begin
          st = ST_FULL;
        end else begin
          for (int i = level; i > pos; i--) shadow[i] = shadow[i-1];
          shadow[pos] = value;
          level++;
        end
      end
      OP_APPEND: begin
        if (level >= DEPTH) begin
          st = ST_FULL;
        end else begin
          shadow[level] = value;
          level++;
        end
      end
      OP_REMOVE: begin
        if (!hit) begin
          st = ST_RANGE;
        end else begin
          for (int i = pos; i + 1 < level; i++) shadow[i] = shadow[i+1];
          level--;
        end
      end
      default: ;
    endcase
    return outcome(rd, st, level);
  endfunction

  // Present one request, hold it until the transfer, then record what it must return.
  task automatic send_request(logic [OP_BITS-1:0] op, logic [POS_BITS-1:0] pos,
                              logic [DATA_BITS-1:0] value, bit typed, result_t want_r);
    result_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, value, pos, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = apply_request(op, pos, value);
    pending_results = {pending_results, (typed ? want_r : predicted)};
  endtask

  // Result side: random stall bursts on m_tready, check every transfer.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[$bits(result_t)-1:0]);
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: %h", m_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.read_value !== want.read_value) begin
          $error("read_value mismatch: expected %h, got %h", want.read_value, got.read_value);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.count !== want.count) begin
          $error("count mismatch: expected %0d, got %0d", want.count, got.count);
          errors++;
        end
        if (got.is_empty !== want.is_empty) begin
          $error("is_empty mismatch: expected %b, got %b", want.is_empty, got.is_empty);
          errors++;
        end
        if (got.is_full !== want.is_full) begin
          $error("is_full mismatch: expected %b, got %b", want.is_full, got.is_full);
          errors++;
        end
        if (m_tdata[OUT_BITS-1:$bits(result_t)] !== '0) begin
          $error("pad mismatch: expected 0, got %h", m_tdata[OUT_BITS-1:$bits(result_t)]);
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_CAP) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                   items_done;
    bit                   grow;
    int unsigned          pick;
    logic [OP_BITS-1:0]   op;
    logic [POS_BITS-1:0]  pos;
    logic [DATA_BITS-1:0] value;

    items_done = 0;
    grow       = 1'b1;

    // Empty store: every positional op is out of range, reserved ops do nothing.
    plan_step(OP_READ,   4'd0,  32'h0,        1, 1, outcome(32'h0, ST_RANGE, 0));
    plan_step(OP_REMOVE, 4'd15, 32'hFFFFFFFF, 1, 1, outcome(32'h0, ST_RANGE, 0));
    plan_step(OP_INSERT, 4'd0,  32'hFFFFFFFF, 1, 1, outcome(32'h0, ST_RANGE, 0));
    plan_step(OP_WRITE,  4'd0,  32'h0,        1, 1, outcome(32'h0, ST_RANGE, 0));
    plan_step(OP_RSVD_C, 4'd15, 32'hFFFFFFFF, 1, 1, outcome(32'h0, ST_DONE, 0));
    // Append ignores the position field.
    plan_step(OP_APPEND, 4'd15, 32'hFFFFFFFF, 1, 1, outcome(32'h0, ST_DONE, 1));
    plan_step(OP_APPEND, 4'd0,  32'h0,        1, 1, outcome(32'h0, ST_DONE, 2));
    plan_step(OP_READ,   4'd0,  32'h0,        1, 1, outcome(32'hFFFFFFFF, ST_DONE, 2));
    plan_step(OP_READ,   4'd1,  32'hFFFFFFFF, 1, 1, outcome(32'h0, ST_DONE, 2));
    plan_step(OP_READ,   4'd2,  32'h0,        1, 1, outcome(32'h0, ST_RANGE, 2));
    // Shifts in both directions, including removal of the last entry.
    plan_step(OP_INSERT, 4'd0,  32'hA5A5A5A5, 1, 0, '0);
    plan_step(OP_WRITE,  4'd1,  32'h5A5A5A5A, 1, 0, '0);
    plan_step(OP_INSERT, 4'd2,  32'h12345678, 1, 0, '0);
    plan_step(OP_READ,   4'd2,  32'h0,        1, 0, '0);
    plan_step(OP_REMOVE, 4'd3,  32'h0,        1, 0, '0);
    plan_step(OP_REMOVE, 4'd0,  32'h0,        1, 0, '0);
    plan_step(OP_RSVD_A, 4'd1,  32'h0F0F0F0F, 1, 0, '0);
    plan_step(OP_RSVD_B, 4'd0,  32'hF0F0F0F0, 1, 0, '0);
    // Fill up, then hit the full store from every side.
    plan_step(OP_APPEND, 4'd0,  32'hC3C3C3C3, DEPTH - 2, 0, '0);
    plan_step(OP_APPEND, 4'd0,  32'hFFFFFFFF, 1, 1, outcome(32'h0, ST_FULL, DEPTH));
    plan_step(OP_INSERT, 4'd15, 32'hFFFFFFFF, 1, 1, outcome(32'h0, ST_FULL, DEPTH));
    plan_step(OP_INSERT, 4'd0,  32'h0,        1, 1, outcome(32'h0, ST_FULL, DEPTH));
    plan_step(OP_WRITE,  4'd15, 32'h0,        1, 0, '0);
    plan_step(OP_READ,   4'd15, 32'h0,        1, 0, '0);
    plan_step(OP_REMOVE, 4'd15, 32'h0,        1, 0, '0);
    plan_step(OP_INSERT, 4'd0,  32'h3C3C3C3C, 1, 0, '0);
    plan_step(OP_REMOVE, 4'd0,  32'h0,        DEPTH, 0, '0);
    plan_step(OP_REMOVE, 4'd0,  32'h0,        1, 1, outcome(32'h0, ST_RANGE, 0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[r]) begin
      for (int k = 0; k < directed_plan[r].reps; k++) begin
        send_request(directed_plan[r].op, directed_plan[r].pos, directed_plan[r].value,
                     directed_plan[r].typed, directed_plan[r].want);
      end
    end

    // Random traffic: mostly in-range requests that sweep the fill level between
    // empty and full, with some out-of-range positions and reserved ops mixed in.
    while (items_done < ITEMS) begin
      if (items_done >= ITEMS - 200) idle_on = 1'b0;
      else if (items_done % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);

      if (level == DEPTH && $urandom_range(0, 2) == 0) grow = 1'b0;
      if (level == 0 && $urandom_range(0, 1) == 0) grow = 1'b1;

      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        op = 3'($urandom_range(OP_RSVD_A, OP_RSVD_C));
      end else if (pick < 12) begin
        op = 3'($urandom_range(OP_READ, OP_REMOVE));
      end else begin
        pick = $urandom_range(0, 99);
        if (grow) begin
          op = (pick < 30) ? OP_APPEND : (pick < 55) ? OP_INSERT :
               (pick < 70) ? OP_READ : (pick < 85) ? OP_WRITE : OP_REMOVE;
        end else begin
          op = (pick < 45) ? OP_REMOVE : (pick < 60) ? OP_READ :
               (pick < 75) ? OP_WRITE : (pick < 90) ? OP_INSERT : OP_APPEND;
        end
      end

      // Keep most positions inside the filled part so requests do real work.
      if (level > 0 && $urandom_range(0, 9) != 0) pos = 4'($urandom_range(0, level - 1));
      else pos = 4'($urandom_range(0, 15));

      pick = $urandom_range(0, 19);
      value = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFFFFFF : $urandom;

      send_request(op, pos, value, 1'b0, '0);
      if (op <= OP_REMOVE) items_done++;
    end
    s_tvalid <= 1'b0;

    // Drain outstanding results, then watch for stray ones.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (QUIET_TAIL) @(posedge clk);

    if (pending_results.size() != 0) begin
      $error("results still outstanding: %0d", pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
